### rtl/bounded_ordered_list_engine_macros.svh
// assertion macros for the bounded ordered list engine
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define BOLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BOLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bole_pkg.sv
// types and constants shared by the bounded ordered list engine
package bole_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   typedef enum logic [3:0] {
      ACT_APPEND     = 4'd0,
      ACT_PREPEND    = 4'd1,
      ACT_TAKE_TAIL  = 4'd2,
      ACT_TAKE_HEAD  = 4'd3,
      ACT_INSERT     = 4'd4,
      ACT_FIND       = 4'd5,
      ACT_DELETE     = 4'd6,
      ACT_SORT       = 4'd7,
      ACT_REVERSE    = 4'd8,
      ACT_CLEAR      = 4'd9,
      ACT_SHOW       = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         position;
      logic signed [31:0] element;
      logic [4:0]         count;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_APPEND,
      OP_DEC,
      OP_CLEAR,
      OP_SU_INIT,
      OP_SU_RD,
      OP_SU_WR,
      OP_SU_FIN,
      OP_SCAN_RD,
      OP_SCAN_NEXT,
      OP_FOUND,
      OP_SD_RD,
      OP_SD_WR,
      OP_SORT_START,
      OP_SORT_LOAD,
      OP_SORT_RD,
      OP_SORT_CMP,
      OP_SORT_END,
      OP_REV_INIT,
      OP_REV_RA,
      OP_REV_RB,
      OP_REV_WA,
      OP_REV_WB,
      OP_SHOW_RD,
      OP_SHOW_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       st_en;
      status_type st;
   } cmd_type;

   typedef struct packed {
      logic [3:0] act;
      logic       full;
      logic       empty;
      logic       few;
      logic       hit;
      logic       i_last;
      logic       j_eq_i;
      logic       i_ge_j;
      logic       j_end;
      logic       pass_last;
   } stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SU_INIT,
      S_SU_RD,
      S_SU_WR,
      S_SD_RD,
      S_SD_WR,
      S_SORT_START,
      S_SORT_LOAD,
      S_SORT_RD,
      S_SORT_CMP,
      S_REV_TEST,
      S_REV_RB,
      S_REV_WA,
      S_REV_WB,
      S_SHOW_RD,
      S_SHOW_EMIT,
      S_RESP
   } ctl_state_type;

endpackage

### rtl/bole_ram.sv
// generic single write port ram with registered read
module bole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/bole_controller.sv
// sequencing state machine of the bounded ordered list engine
module bole_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_strobe,
   input  bole_pkg::stat_type stat,
   output bole_pkg::cmd_type  cmd
);

   bole_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bole_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bole_pkg::S_IDLE: begin
            if (start) state_in = bole_pkg::S_DISPATCH;
         end
         bole_pkg::S_DISPATCH: begin
            state_in = bole_pkg::S_RESP;
            case (stat.act)
               bole_pkg::ACT_PREPEND: begin
                  if (!stat.full) state_in = bole_pkg::S_SU_INIT;
               end
               bole_pkg::ACT_INSERT: begin
                  if (stat.empty) state_in = bole_pkg::S_SU_INIT;
                  else if (!stat.full) state_in = bole_pkg::S_SCAN_RD;
               end
               bole_pkg::ACT_TAKE_HEAD: begin
                  if (!stat.empty) state_in = bole_pkg::S_SD_RD;
               end
               bole_pkg::ACT_FIND, bole_pkg::ACT_DELETE: begin
                  if (!stat.empty) state_in = bole_pkg::S_SCAN_RD;
               end
               bole_pkg::ACT_SORT: begin
                  if (!stat.few) state_in = bole_pkg::S_SORT_START;
               end
               bole_pkg::ACT_REVERSE: begin
                  if (!stat.few) state_in = bole_pkg::S_REV_TEST;
               end
               bole_pkg::ACT_SHOW: begin
                  if (!stat.empty) state_in = bole_pkg::S_SHOW_RD;
               end
               default: state_in = bole_pkg::S_RESP;
            endcase
         end
         bole_pkg::S_SCAN_RD: state_in = bole_pkg::S_SCAN_CHK;
         bole_pkg::S_SCAN_CHK: begin
            if (stat.hit) begin
               if (stat.act == bole_pkg::ACT_INSERT) begin
                  state_in = bole_pkg::S_SU_INIT;
               end else if (stat.act == bole_pkg::ACT_DELETE) begin
                  state_in = bole_pkg::S_SD_RD;
               end else begin
                  state_in = bole_pkg::S_RESP;
               end
            end else if (stat.i_last) begin
               if (stat.act == bole_pkg::ACT_INSERT) begin
                  state_in = bole_pkg::S_SU_INIT;
               end else begin
                  state_in = bole_pkg::S_RESP;
               end
            end else begin
               state_in = bole_pkg::S_SCAN_RD;
            end
         end
         bole_pkg::S_SU_INIT: state_in = bole_pkg::S_SU_RD;
         bole_pkg::S_SU_RD: begin
            state_in = stat.j_eq_i ? bole_pkg::S_RESP : bole_pkg::S_SU_WR;
         end
         bole_pkg::S_SU_WR: state_in = bole_pkg::S_SU_RD;
         bole_pkg::S_SD_RD: begin
            state_in = stat.i_last ? bole_pkg::S_RESP : bole_pkg::S_SD_WR;
         end
         bole_pkg::S_SD_WR: state_in = bole_pkg::S_SD_RD;
         bole_pkg::S_SORT_START: state_in = bole_pkg::S_SORT_LOAD;
         bole_pkg::S_SORT_LOAD: state_in = bole_pkg::S_SORT_RD;
         bole_pkg::S_SORT_RD: begin
            if (stat.j_end) begin
               state_in = stat.pass_last ? bole_pkg::S_RESP : bole_pkg::S_SORT_START;
            end else begin
               state_in = bole_pkg::S_SORT_CMP;
            end
         end
         bole_pkg::S_SORT_CMP: state_in = bole_pkg::S_SORT_RD;
         bole_pkg::S_REV_TEST: begin
            state_in = stat.i_ge_j ? bole_pkg::S_RESP : bole_pkg::S_REV_RB;
         end
         bole_pkg::S_REV_RB: state_in = bole_pkg::S_REV_WA;
         bole_pkg::S_REV_WA: state_in = bole_pkg::S_REV_WB;
         bole_pkg::S_REV_WB: state_in = bole_pkg::S_REV_TEST;
         bole_pkg::S_SHOW_RD: state_in = bole_pkg::S_SHOW_EMIT;
         bole_pkg::S_SHOW_EMIT: begin
            state_in = stat.i_last ? bole_pkg::S_IDLE : bole_pkg::S_SHOW_RD;
         end
         bole_pkg::S_RESP: state_in = bole_pkg::S_IDLE;
         default: state_in = bole_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op     = bole_pkg::OP_NONE;
      cmd.st_en  = 1'b0;
      cmd.st     = bole_pkg::ST_OK;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         bole_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) cmd.op = bole_pkg::OP_LOAD;
         end
         bole_pkg::S_DISPATCH: begin
            case (stat.act)
               bole_pkg::ACT_APPEND: begin
                  if (stat.full) begin
                     cmd.st_en = 1'b1;
                     cmd.st    = bole_pkg::ST_FULL;
                  end else begin
                     cmd.op = bole_pkg::OP_APPEND;
                  end
               end
               bole_pkg::ACT_PREPEND, bole_pkg::ACT_INSERT: begin
                  if (stat.full) begin
                     cmd.st_en = 1'b1;
                     cmd.st    = bole_pkg::ST_FULL;
                  end
               end
               bole_pkg::ACT_TAKE_TAIL: begin
                  if (stat.empty) begin
                     cmd.st_en = 1'b1;
                     cmd.st    = bole_pkg::ST_EMPTY;
                  end else begin
                     cmd.op = bole_pkg::OP_DEC;
                  end
               end
               bole_pkg::ACT_TAKE_HEAD, bole_pkg::ACT_DELETE, bole_pkg::ACT_SHOW: begin
                  if (stat.empty) begin
                     cmd.st_en = 1'b1;
                     cmd.st    = bole_pkg::ST_EMPTY;
                  end
               end
               bole_pkg::ACT_FIND: begin
                  if (stat.empty) begin
                     cmd.st_en = 1'b1;
                     cmd.st    = bole_pkg::ST_MISSING;
                  end
               end
               bole_pkg::ACT_REVERSE: begin
                  if (!stat.few) cmd.op = bole_pkg::OP_REV_INIT;
               end
               bole_pkg::ACT_CLEAR: cmd.op = bole_pkg::OP_CLEAR;
               default: cmd.op = bole_pkg::OP_NONE;
            endcase
         end
         bole_pkg::S_SCAN_RD: cmd.op = bole_pkg::OP_SCAN_RD;
         bole_pkg::S_SCAN_CHK: begin
            if (stat.hit) begin
               if (stat.act == bole_pkg::ACT_FIND) cmd.op = bole_pkg::OP_FOUND;
            end else if (stat.i_last) begin
               if (stat.act == bole_pkg::ACT_INSERT) begin
                  cmd.op = bole_pkg::OP_SCAN_NEXT;
               end else begin
                  cmd.st_en = 1'b1;
                  cmd.st    = bole_pkg::ST_MISSING;
               end
            end else begin
               cmd.op = bole_pkg::OP_SCAN_NEXT;
            end
         end
         bole_pkg::S_SU_INIT: cmd.op = bole_pkg::OP_SU_INIT;
         bole_pkg::S_SU_RD: begin
            cmd.op = stat.j_eq_i ? bole_pkg::OP_SU_FIN : bole_pkg::OP_SU_RD;
         end
         bole_pkg::S_SU_WR: cmd.op = bole_pkg::OP_SU_WR;
         bole_pkg::S_SD_RD: begin
            cmd.op = stat.i_last ? bole_pkg::OP_DEC : bole_pkg::OP_SD_RD;
         end
         bole_pkg::S_SD_WR: cmd.op = bole_pkg::OP_SD_WR;
         bole_pkg::S_SORT_START: cmd.op = bole_pkg::OP_SORT_START;
         bole_pkg::S_SORT_LOAD: cmd.op = bole_pkg::OP_SORT_LOAD;
         bole_pkg::S_SORT_RD: begin
            cmd.op = stat.j_end ? bole_pkg::OP_SORT_END : bole_pkg::OP_SORT_RD;
         end
         bole_pkg::S_SORT_CMP: cmd.op = bole_pkg::OP_SORT_CMP;
         bole_pkg::S_REV_TEST: begin
            if (!stat.i_ge_j) cmd.op = bole_pkg::OP_REV_RA;
         end
         bole_pkg::S_REV_RB: cmd.op = bole_pkg::OP_REV_RB;
         bole_pkg::S_REV_WA: cmd.op = bole_pkg::OP_REV_WA;
         bole_pkg::S_REV_WB: cmd.op = bole_pkg::OP_REV_WB;
         bole_pkg::S_SHOW_RD: cmd.op = bole_pkg::OP_SHOW_RD;
         bole_pkg::S_SHOW_EMIT: begin
            cmd.op     = bole_pkg::OP_SHOW_EMIT;
            rsp_strobe = 1'b1;
         end
         bole_pkg::S_RESP: rsp_strobe = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

### rtl/bole_datapath.sv
// registers, element store and compares of the bounded ordered list engine
module bole_datapath #(
   parameter int DEPTH      = bole_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bole_pkg::req_type  req,
   input  bole_pkg::cmd_type  cmd,
   output bole_pkg::stat_type stat,
   output bole_pkg::rsp_type  rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [3:0]                  act_ff, act_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [CW-1:0]               i_ff, i_in;
   logic [CW-1:0]               j_ff, j_in;
   logic [CW-1:0]               p_ff, p_in;
   logic signed [DATA_WIDTH-1:0] hold_ff, hold_in;
   bole_pkg::status_type        st_ff, st_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic signed [DATA_WIDTH-1:0] elem_ff, elem_in;

   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic signed [DATA_WIDTH-1:0] wr_data;
   logic [IW-1:0]                rd_addr;
   logic signed [DATA_WIDTH-1:0] rd_data;

   logic [CW-1:0] i_inc, j_inc, j_dec, cnt_inc, cnt_dec;

   assign i_inc   = i_ff + CW'(1);
   assign j_inc   = j_ff + CW'(1);
   assign j_dec   = j_ff - CW'(1);
   assign cnt_inc = cnt_ff + CW'(1);
   assign cnt_dec = cnt_ff - CW'(1);

   bole_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      act_ff  <= act_in;
      key_ff  <= key_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      p_ff    <= p_in;
      hold_ff <= hold_in;
      st_ff   <= st_in;
      pos_ff  <= pos_in;
      elem_ff <= elem_in;
   end

   always_comb begin
      act_in  = act_ff;
      key_in  = key_ff;
      cnt_in  = cnt_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      p_in    = p_ff;
      hold_in = hold_ff;
      st_in   = st_ff;
      pos_in  = pos_ff;
      elem_in = elem_ff;
      wr_en   = 1'b0;
      wr_addr = i_ff[IW-1:0];
      wr_data = rd_data;
      rd_addr = i_ff[IW-1:0];
      case (cmd.op)
         bole_pkg::OP_LOAD: begin
            act_in  = req.action;
            key_in  = DATA_WIDTH'(req.value);
            i_in    = '0;
            j_in    = '0;
            p_in    = '0;
            st_in   = bole_pkg::ST_OK;
            pos_in  = '0;
            elem_in = '0;
         end
         bole_pkg::OP_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IW-1:0];
            wr_data = key_ff;
            cnt_in  = cnt_inc;
         end
         bole_pkg::OP_DEC: cnt_in = cnt_dec;
         bole_pkg::OP_CLEAR: cnt_in = '0;
         bole_pkg::OP_SU_INIT: j_in = cnt_ff;
         bole_pkg::OP_SU_RD: rd_addr = j_dec[IW-1:0];
         bole_pkg::OP_SU_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IW-1:0];
            j_in    = j_dec;
         end
         bole_pkg::OP_SU_FIN: begin
            wr_en   = 1'b1;
            wr_data = key_ff;
            cnt_in  = cnt_inc;
         end
         bole_pkg::OP_SCAN_RD: rd_addr = i_ff[IW-1:0];
         bole_pkg::OP_SCAN_NEXT: i_in = i_inc;
         bole_pkg::OP_FOUND: begin
            pos_in  = i_ff;
            elem_in = rd_data;
         end
         bole_pkg::OP_SD_RD: rd_addr = i_inc[IW-1:0];
         bole_pkg::OP_SD_WR: begin
            wr_en = 1'b1;
            i_in  = i_inc;
         end
         bole_pkg::OP_SORT_START: begin
            rd_addr = '0;
            j_in    = CW'(1);
         end
         bole_pkg::OP_SORT_LOAD: hold_in = rd_data;
         bole_pkg::OP_SORT_RD: rd_addr = j_ff[IW-1:0];
         bole_pkg::OP_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_dec[IW-1:0];
            if (hold_ff > rd_data) begin
               wr_data = rd_data;
            end else begin
               wr_data = hold_ff;
               hold_in = rd_data;
            end
            j_in = j_inc;
         end
         bole_pkg::OP_SORT_END: begin
            wr_en   = 1'b1;
            wr_addr = cnt_dec[IW-1:0];
            wr_data = hold_ff;
            p_in    = p_ff + CW'(1);
         end
         bole_pkg::OP_REV_INIT: j_in = cnt_dec;
         bole_pkg::OP_REV_RA: rd_addr = i_ff[IW-1:0];
         bole_pkg::OP_REV_RB: begin
            hold_in = rd_data;
            rd_addr = j_ff[IW-1:0];
         end
         bole_pkg::OP_REV_WA: wr_en = 1'b1;
         bole_pkg::OP_REV_WB: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[IW-1:0];
            wr_data = hold_ff;
            i_in    = i_inc;
            j_in    = j_dec;
         end
         bole_pkg::OP_SHOW_RD: rd_addr = i_ff[IW-1:0];
         bole_pkg::OP_SHOW_EMIT: i_in = i_inc;
         default: wr_en = 1'b0;
      endcase
      if (cmd.st_en) st_in = cmd.st;
   end

   // status towards the controller
   always_comb begin
      stat.act       = act_ff;
      stat.full      = (cnt_ff == CW'(DEPTH));
      stat.empty     = (cnt_ff == '0);
      stat.few       = (cnt_ff < CW'(2));
      stat.hit       = (act_ff == bole_pkg::ACT_INSERT) ? !(rd_data < key_ff)
                                                        : (rd_data == key_ff);
      stat.i_last    = ((CW+1)'(i_ff) + (CW+1)'(1)) == (CW+1)'(cnt_ff);
      stat.j_eq_i    = (j_ff == i_ff);
      stat.i_ge_j    = (i_ff >= j_ff);
      stat.j_end     = (j_ff == cnt_ff);
      stat.pass_last = ((CW+1)'(p_ff) + (CW+1)'(2)) == (CW+1)'(cnt_ff);
   end

   // result transaction
   always_comb begin
      if (cmd.op == bole_pkg::OP_SHOW_EMIT) begin
         rsp.status   = bole_pkg::ST_OK;
         rsp.position = 4'(i_ff);
         rsp.element  = 32'(rd_data);
         rsp.count    = 5'(cnt_ff);
         rsp.last     = stat.i_last;
      end else begin
         rsp.status   = st_ff;
         rsp.position = 4'(pos_ff);
         rsp.element  = 32'(elem_ff);
         rsp.count    = 5'(cnt_ff);
         rsp.last     = 1'b1;
      end
   end

endmodule

### rtl/bounded_ordered_list_engine.sv
// top level of the bounded ordered list engine
//
//  channel   ports                         handshake
//  request   start, busy, req              taken when start high and busy low
//  response  rsp_strobe, rsp               one-cycle strobe per result, no back-pressure
//
//  append, tail removal and clear go from dispatch straight to the response; other
//  single-result actions walk the element ram at one read port.
//  sort is bubble sort: one pass per element but one, for n elements.
//  show reads and then emits each element in turn, one result per element, last marked.
//  synchronous reset empties the list at once; entries need no clearing.
//  busy stays high from acceptance until the final result strobe.
module bounded_ordered_list_engine #(
   parameter int DEPTH      = bole_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bole_pkg::req_type req,
   output logic              rsp_strobe,
   output bole_pkg::rsp_type rsp
);

   bole_pkg::cmd_type  cmd;
   bole_pkg::stat_type stat;

   bole_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   bole_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp)
   );

endmodule

### rtl/bole_checker.sv
// port checks for the bounded ordered list engine and their binding
`include "bounded_ordered_list_engine_macros.svh"

module bole_checker #(
   parameter int DEPTH = bole_pkg::DEPTH_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input bole_pkg::rsp_type rsp
);

   `BOLE_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy, "result while idle")
   `BOLE_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `BOLE_ASSERT_NXT(a_last_ends, clock, reset, rsp_strobe && rsp.last, !rsp_strobe && !busy, "transaction runs past last")
   `BOLE_ASSERT_IMP(a_full_count, clock, reset, rsp_strobe && rsp.status == bole_pkg::ST_FULL, rsp.count == 5'(DEPTH), "full with room")
   `BOLE_ASSERT_IMP(a_empty_count, clock, reset, rsp_strobe && rsp.status == bole_pkg::ST_EMPTY, rsp.count == 5'd0 && rsp.last, "empty with elements")

endmodule

bind bounded_ordered_list_engine bole_checker #(.DEPTH(DEPTH)) u_chk (.*);
